FILE: rtl/notification_banner_controller_assert.svh
// Assertion macros shared by the notification banner controller checkers.
// Depends on nothing; the files that use it supply aclk and aresetn.
`ifndef NOTIFICATION_BANNER_CONTROLLER_ASSERT_SVH
`define NOTIFICATION_BANNER_CONTROLLER_ASSERT_SVH

// Concurrent assertion on a given clock, switched off while reset is low.
`define NBC_ASSERT_ON(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Same, on the block clock and reset.
`define NBC_ASSERT(label, prop, msg) \
    `NBC_ASSERT_ON(label, aclk, aresetn, prop, msg)

`endif

FILE: rtl/nbc_pkg.sv
// Package of the notification banner controller: item types, codes, reset values.
// Depends on nothing.
package nbc_pkg;

    localparam int unsigned TIME_W = 32;

    typedef logic [1:0]        op_t;
    typedef logic [2:0]        src_t;
    typedef logic [1:0]        cfg_idx_t;
    typedef logic [TIME_W-1:0] ms_t;

    localparam op_t OP_UPDATE  = 2'd0;
    localparam op_t OP_BATTERY = 2'd1;
    localparam op_t OP_DRAW    = 2'd2;

    localparam src_t SRC_NONE   = 3'd0;
    localparam src_t SRC_EMPTY  = 3'd1;
    localparam src_t SRC_LOW    = 3'd2;
    localparam src_t SRC_UPDATE = 3'd3;
    localparam src_t SRC_NEARBY = 3'd4;

    localparam logic [1:0] LEVEL_OK   = 2'd0;
    localparam logic [1:0] LEVEL_LOW  = 2'd1;
    localparam logic [1:0] LEVEL_CRIT = 2'd2;

    localparam cfg_idx_t CFG_UPDATE_HOLD    = 2'd0;
    localparam cfg_idx_t CFG_BATTERY_CHECK  = 2'd1;
    localparam cfg_idx_t CFG_BATTERY_HOLD   = 2'd2;
    localparam cfg_idx_t CFG_BATTERY_REPEAT = 2'd3;

    localparam ms_t UPDATE_HOLD_RST    = 32'd5000;
    localparam ms_t BATTERY_CHECK_RST  = 32'd1000;
    localparam ms_t BATTERY_HOLD_RST   = 32'd5000;
    localparam ms_t BATTERY_REPEAT_RST = 32'd60000;

    typedef struct packed {
        ms_t update_hold;
        ms_t battery_check;
        ms_t battery_hold;
        ms_t battery_repeat;
    } nbc_cfg_t;

    typedef struct packed {
        op_t  op;
        ms_t  now_ms;
        logic update_due;
        logic battery_low;
        logic battery_critical;
        logic nearby_present;
        logic screen_repainted;
    } nbc_item_t;

    typedef struct packed {
        logic chrome_request;
        logic mark_shown;
        logic paint;
        src_t banner_source;
    } nbc_result_t;

endpackage

FILE: rtl/nbc_cfg.sv
// Configuration register file of the notification banner controller.
// Depends on nbc_pkg.
module nbc_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  nbc_pkg::cfg_idx_t cfg_index,
    input  nbc_pkg::ms_t      cfg_wdata,
    output nbc_pkg::nbc_cfg_t cfg
);
    import nbc_pkg::*;

    nbc_cfg_t cfg_reg;
    nbc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_UPDATE_HOLD:    cfg_next.update_hold    = cfg_wdata;
                CFG_BATTERY_CHECK:  cfg_next.battery_check  = cfg_wdata;
                CFG_BATTERY_HOLD:   cfg_next.battery_hold   = cfg_wdata;
                CFG_BATTERY_REPEAT: cfg_next.battery_repeat = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.update_hold    <= UPDATE_HOLD_RST;
            cfg_reg.battery_check  <= BATTERY_CHECK_RST;
            cfg_reg.battery_hold   <= BATTERY_HOLD_RST;
            cfg_reg.battery_repeat <= BATTERY_REPEAT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/nbc_core.sv
// Banner state and the per-item update logic of the notification banner controller.
// Depends on nbc_pkg.
module nbc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 commit,
    input  nbc_pkg::nbc_item_t   item,
    input  nbc_pkg::nbc_cfg_t    cfg,
    output nbc_pkg::nbc_result_t result
);
    import nbc_pkg::*;

    logic       update_active_reg,       update_active_next;
    ms_t        update_shown_time_reg,   update_shown_time_next;
    ms_t        battery_check_time_reg,  battery_check_time_next;
    logic [1:0] battery_level_reg,       battery_level_next;
    logic [1:0] battery_banner_reg,      battery_banner_next;
    ms_t        battery_shown_time_reg,  battery_shown_time_next;
    ms_t        battery_hidden_time_reg, battery_hidden_time_next;
    logic       battery_ever_hidden_reg, battery_ever_hidden_next;
    logic       paint_pending_reg,       paint_pending_next;

    // Elapsed times, all modulo 2^32.
    ms_t since_update;
    ms_t since_check;
    ms_t since_shown;
    ms_t since_hidden;

    assign since_update = item.now_ms - update_shown_time_reg;
    assign since_check  = item.now_ms - battery_check_time_reg;
    assign since_shown  = item.now_ms - battery_shown_time_reg;
    assign since_hidden = item.now_ms - battery_hidden_time_reg;

    always_comb begin
        logic       req;
        logic [1:0] level;
        logic       changed;
        logic [1:0] banner_mid;
        logic       ever_mid;
        src_t       src;

        update_active_next       = update_active_reg;
        update_shown_time_next   = update_shown_time_reg;
        battery_check_time_next  = battery_check_time_reg;
        battery_level_next       = battery_level_reg;
        battery_banner_next      = battery_banner_reg;
        battery_shown_time_next  = battery_shown_time_reg;
        battery_hidden_time_next = battery_hidden_time_reg;
        battery_ever_hidden_next = battery_ever_hidden_reg;
        paint_pending_next       = paint_pending_reg;
        result                   = '0;
        req                      = 1'b0;
        level = item.battery_critical ? LEVEL_CRIT :
                (item.battery_low ? LEVEL_LOW : LEVEL_OK);
        changed    = (level != battery_level_reg);
        banner_mid = changed ? 2'd0 : battery_banner_reg;
        ever_mid   = changed ? 1'b0 : battery_ever_hidden_reg;
        src        = SRC_NONE;

        case (item.op)
            OP_UPDATE: begin
                if (update_active_reg) begin
                    if (since_update >= cfg.update_hold) begin
                        update_active_next = 1'b0;
                        req                = 1'b1;
                    end
                end else if (item.update_due) begin
                    update_active_next     = 1'b1;
                    update_shown_time_next = item.now_ms;
                    result.mark_shown      = 1'b1;
                    req                    = 1'b1;
                end
            end
            OP_BATTERY: begin
                // A stored check time of zero is treated as never checked.
                if (battery_check_time_reg == '0 || since_check >= cfg.battery_check) begin
                    battery_check_time_next  = item.now_ms;
                    battery_level_next       = level;
                    battery_banner_next      = banner_mid;
                    battery_ever_hidden_next = ever_mid;
                    req = changed && (battery_banner_reg != 2'd0);
                    if (level == LEVEL_OK) begin
                        // Banner is already cleared above when the level changed.
                        battery_banner_next = 2'd0;
                        req = req || (banner_mid != 2'd0);
                    end else if (banner_mid != 2'd0) begin
                        if (since_shown >= cfg.battery_hold) begin
                            battery_banner_next      = 2'd0;
                            battery_hidden_time_next = item.now_ms;
                            battery_ever_hidden_next = 1'b1;
                            req                      = 1'b1;
                        end
                    end else if (!(ever_mid && since_hidden < cfg.battery_repeat)) begin
                        battery_banner_next = (level == LEVEL_CRIT) ? SRC_EMPTY[1:0]
                                                                    : SRC_LOW[1:0];
                        battery_shown_time_next = item.now_ms;
                        req                     = 1'b1;
                    end
                end
            end
            OP_DRAW: begin
                if (battery_banner_reg != 2'd0) begin
                    src = {1'b0, battery_banner_reg};
                end else if (update_active_reg) begin
                    src = SRC_UPDATE;
                end else if (item.nearby_present) begin
                    src = SRC_NEARBY;
                end
                if (src == SRC_NONE) begin
                    paint_pending_next = 1'b0;
                end else if (paint_pending_reg || item.screen_repainted) begin
                    paint_pending_next = 1'b0;
                    result.paint       = 1'b1;
                end
                result.banner_source = src;
            end
            default: begin
                result = '0;
            end
        endcase

        if (req) begin
            paint_pending_next = 1'b1;
        end
        result.chrome_request = req;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            update_active_reg       <= 1'b0;
            update_shown_time_reg   <= '0;
            battery_check_time_reg  <= '0;
            battery_level_reg       <= LEVEL_OK;
            battery_banner_reg      <= 2'd0;
            battery_shown_time_reg  <= '0;
            battery_hidden_time_reg <= '0;
            battery_ever_hidden_reg <= 1'b0;
            paint_pending_reg       <= 1'b0;
        end else if (commit) begin
            update_active_reg       <= update_active_next;
            update_shown_time_reg   <= update_shown_time_next;
            battery_check_time_reg  <= battery_check_time_next;
            battery_level_reg       <= battery_level_next;
            battery_banner_reg      <= battery_banner_next;
            battery_shown_time_reg  <= battery_shown_time_next;
            battery_hidden_time_reg <= battery_hidden_time_next;
            battery_ever_hidden_reg <= battery_ever_hidden_next;
            paint_pending_reg       <= paint_pending_next;
        end
    end

endmodule

FILE: rtl/notification_banner_controller.sv
// Top level of the notification banner controller: input register, core, result register.
// Depends on nbc_pkg, nbc_cfg and nbc_core.
//
// The controller takes one request per clock cycle and returns exactly one result per
// request. A request is first captured in an input register; from there the banner
// state logic evaluates it against the current state, commits the new state and loads
// the result register. As the state is written at the same edge as the result, the
// following request already sees its effect, so back-to-back requests need no bubbles.
// The throughput is set by that single state-update stage: one request per cycle
// while m_ready is high. When the result side stalls, the result register holds its
// value and the input register can still take one more request, after which s_ready
// drops. Op 0 is an update-notice tick, op 1 a battery tick and op 2 a draw; op 3
// changes nothing and returns all zero fields. Configuration is written through
// cfg_wr_en, cfg_index and cfg_wdata and must only be written while no request is in
// flight.
module notification_banner_controller (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  nbc_pkg::cfg_idx_t cfg_index,
    input  nbc_pkg::ms_t      cfg_wdata,

    input  logic              s_valid,
    output logic              s_ready,
    input  nbc_pkg::op_t      s_op,
    input  nbc_pkg::ms_t      s_now_ms,
    input  logic              s_update_due,
    input  logic              s_battery_low,
    input  logic              s_battery_critical,
    input  logic              s_nearby_present,
    input  logic              s_screen_repainted,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_chrome_request,
    output logic              m_mark_shown,
    output logic              m_paint,
    output nbc_pkg::src_t     m_banner_source
);
    import nbc_pkg::*;

    nbc_cfg_t    cfg;
    nbc_result_t core_result;

    logic        in_valid_reg,  in_valid_next;
    nbc_item_t   in_item_reg;
    logic        out_valid_reg, out_valid_next;
    nbc_result_t out_result_reg;

    logic        s_take;
    logic        advance;
    logic        fire;

    // The stage holding a request moves on when the result register is free or drains.
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    nbc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nbc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.op               <= s_op;
            in_item_reg.now_ms           <= s_now_ms;
            in_item_reg.update_due       <= s_update_due;
            in_item_reg.battery_low      <= s_battery_low;
            in_item_reg.battery_critical <= s_battery_critical;
            in_item_reg.nearby_present   <= s_nearby_present;
            in_item_reg.screen_repainted <= s_screen_repainted;
        end
        if (fire) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_chrome_request = out_result_reg.chrome_request;
    assign m_mark_shown     = out_result_reg.mark_shown;
    assign m_paint          = out_result_reg.paint;
    assign m_banner_source  = out_result_reg.banner_source;

endmodule

FILE: rtl/nbc_checker.sv
// Port-level assertion checker of the notification banner controller, with its bind.
// Depends on nbc_pkg and notification_banner_controller_assert.svh.
`include "notification_banner_controller_assert.svh"

module nbc_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input logic          m_chrome_request,
    input logic          m_mark_shown,
    input logic          m_paint,
    input nbc_pkg::src_t m_banner_source
);
    import nbc_pkg::*;

    // A stalled result keeps its paint, banner source and repaint request fields.
    `NBC_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_paint) && $stable(m_banner_source) && $stable(m_chrome_request), "stalled result changed")

    // A paint always names the banner it paints.
    `NBC_ASSERT(a_paint_has_source, m_valid && m_paint |-> m_banner_source != SRC_NONE, "paint without source")

    // Raising the update notice always asks for a header repaint.
    `NBC_ASSERT(a_mark_needs_chrome, m_valid && m_mark_shown |-> m_chrome_request, "mark without repaint")

    // Tick results never carry draw fields.
    `NBC_ASSERT(a_tick_no_draw, m_valid && m_chrome_request |-> !m_paint && m_banner_source == SRC_NONE, "tick result has draw fields")

endmodule

bind notification_banner_controller nbc_checker u_nbc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_chrome_request (m_chrome_request),
    .m_mark_shown     (m_mark_shown),
    .m_paint          (m_paint),
    .m_banner_source  (m_banner_source)
);
